### rtl/core/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// shared types and constants of the prime-field point scalar multiplier
// ----------------------------------------------------------------------------
package ecsm_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int SCALAR_BITS = 16;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_B = 2'd2;

  localparam logic [FIELD_BITS-1:0] MODULUS_RST = FIELD_BITS'(10007);
  localparam logic [FIELD_BITS-1:0] CURVE_A_RST = FIELD_BITS'(1);
  localparam logic [FIELD_BITS-1:0] CURVE_B_RST = FIELD_BITS'(1);

  typedef struct packed {
    logic [FIELD_BITS-1:0]  base_x;
    logic [FIELD_BITS-1:0]  base_y;
    logic [SCALAR_BITS-1:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] result_x;
    logic [FIELD_BITS-1:0] result_y;
    logic                  at_infinity;
    logic                  on_curve;
  } out_item_t;

  // operations of the shared field unit
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } alu_rsp_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE, S_RED_BX, S_RED_BY, S_RED_A, S_RED_B,
    S_DBL_CHK, S_DBL_NEG, S_SQ, S_TRI0, S_TRI1, S_ADD_A, S_TWO_Y,
    S_INV_INIT, S_INV_TEST, S_INV_DIV, S_INV_MUL, S_INV_SUB, S_INV_END,
    S_SLOPE, S_LL, S_X1, S_X2, S_DX, S_LM, S_Y,
    S_ADD_CHK, S_ADD_NEG, S_DIFF_Y, S_DIFF_X, S_NEXT,
    S_CHK, S_C_LHS, S_C_X2, S_C_X3, S_C_AX, S_C_S1, S_C_S2, S_OUT
  } seq_state_e;

endpackage

### rtl/core/ecsm_alu.sv
// ----------------------------------------------------------------------------
// ecsm_alu
// shared modular unit: add, subtract, bit-serial multiply, restoring divide
// ----------------------------------------------------------------------------
module ecsm_alu #(
  parameter int W = ecsm_pkg::FIELD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecsm_pkg::alu_req_t req_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  logic [W-1:0]       m_i,
  output ecsm_pkg::alu_rsp_t rsp_o,
  output logic [W-1:0]       res_o,
  output logic [W-1:0]       rem_o
);

  localparam int CntW = (W > 1) ? $clog2(W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  ecsm_pkg::alu_op_e op_q, op_d;
  logic [W-1:0]      acc_q, acc_d;
  logic [W-1:0]      sh_q, sh_d;
  logic [W-1:0]      dv_q, dv_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [W:0] m_ext, dbl, dbl_r, sum, trial, s_add, s_sub;
  logic [W-1:0] mul_next, div_rem, add_res, sub_res;
  logic         div_ge;

  // one multiply step: r = 2r (+ a) mod m
  always_comb begin
    m_ext    = {1'b0, m_i};
    dbl      = {acc_q, 1'b0};
    dbl_r    = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum      = dbl_r + {1'b0, dv_q};
    mul_next = sh_q[W-1] ? ((sum >= m_ext) ? W'(sum - m_ext) : W'(sum)) : W'(dbl_r);
    trial    = {acc_q, sh_q[W-1]};
    div_ge   = trial >= {1'b0, dv_q};
    div_rem  = div_ge ? W'(trial - {1'b0, dv_q}) : W'(trial);
    s_add    = {1'b0, a_i} + {1'b0, b_i};
    add_res  = (s_add >= m_ext) ? W'(s_add - m_ext) : W'(s_add);
    s_sub    = {1'b0, a_i} + m_ext - {1'b0, b_i};
    sub_res  = (a_i >= b_i) ? (a_i - b_i) : W'(s_sub);
  end

  // operation control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      op_d = req_i.op;
      unique case (req_i.op)
        ecsm_pkg::OP_ADD: begin
          acc_d  = add_res;
          done_d = 1'b1;
        end
        ecsm_pkg::OP_SUB: begin
          acc_d  = sub_res;
          done_d = 1'b1;
        end
        ecsm_pkg::OP_MUL: begin
          acc_d  = '0;
          sh_d   = b_i;
          dv_d   = a_i;
          busy_d = 1'b1;
          cnt_d  = CntW'(W - 1);
        end
        ecsm_pkg::OP_DIV: begin
          acc_d  = '0;
          sh_d   = a_i;
          dv_d   = b_i;
          busy_d = 1'b1;
          cnt_d  = CntW'(W - 1);
        end
        default: ;
      endcase
    end else if (busy_q) begin
      if (op_q == ecsm_pkg::OP_DIV) begin
        acc_d = div_rem;
        sh_d  = {sh_q[W-2:0], div_ge};
      end else begin
        acc_d = mul_next;
        sh_d  = {sh_q[W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ecsm_pkg::OP_ADD;
      acc_q  <= '0;
      sh_q   <= '0;
      dv_q   <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      acc_q  <= acc_d;
      sh_q   <= sh_d;
      dv_q   <= dv_d;
      cnt_q  <= cnt_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign res_o      = (op_q == ecsm_pkg::OP_DIV) ? sh_q : acc_q;
  assign rem_o      = acc_q;

`ifndef ASSERT_OFF
  // a new operation never starts while a serial one runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !req_i.start)
    else $error("alu started while busy");
  // completion flag is a single pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("alu done held high");
  // results of add and subtract stay below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (op_q == ecsm_pkg::OP_ADD || op_q == ecsm_pkg::OP_SUB) && m_i != '0)
      |-> acc_q < m_i)
    else $error("alu add/sub out of range");
`endif

endmodule

### rtl/core/ec_point_scalar_multiply_gfp.sv
// Multiply and divide run bit-serially on the shared unit; each item walks through every scalar bit.
// Throughput: one item at a time; input stalls from acceptance until the result transfers.
// Reset: asynchronous active low; configuration registers return to modulus 10007, a = 1, b = 1.
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_gfp
// affine double-and-add scalar multiplication on y^2 = x^3 + ax + b over GF(p)
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply_gfp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ecsm_pkg::FIELD_BITS-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ecsm_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ecsm_pkg::out_item_t                 out_data_o
);

  localparam int FW = ecsm_pkg::FIELD_BITS;
  localparam int SW = ecsm_pkg::SCALAR_BITS;
  localparam int IW = (SW > 1) ? $clog2(SW) : 1;

  ecsm_pkg::seq_state_e state_q, state_d;

  logic [FW-1:0] m_q, ca_q, cb_q;
  logic [FW-1:0] bx_q, bx_d, by_q, by_d, ar_q, ar_d, br_q, br_d;
  logic [FW-1:0] ax_q, ax_d, ay_q, ay_d, ox_q, ox_d;
  logic [FW-1:0] num_q, num_d, den_q, den_d, lam_q, lam_d, e0_q, e0_d, e1_q, e1_d;
  logic [FW-1:0] r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d, qt_q, qt_d, nr_q, nr_d;
  logic [SW-1:0] k_q, k_d;
  logic [IW-1:0] i_q, i_d;
  logic          av_q, av_d, ph_add_q, ph_add_d, issued_q, issued_d;
  logic          ov_q, ov_d;
  ecsm_pkg::out_item_t res_q, res_d;

  ecsm_pkg::alu_req_t alu_req;
  ecsm_pkg::alu_rsp_t alu_rsp;
  ecsm_pkg::alu_op_e  op;
  logic [FW-1:0]      opa, opb, alu_res, alu_rem;
  logic               is_op, fin;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q  <= ecsm_pkg::MODULUS_RST;
      ca_q <= ecsm_pkg::CURVE_A_RST;
      cb_q <= ecsm_pkg::CURVE_B_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ecsm_pkg::REG_MODULUS) m_q <= cfg_wdata_i;
      if (cfg_idx_i == ecsm_pkg::REG_CURVE_A) ca_q <= cfg_wdata_i;
      if (cfg_idx_i == ecsm_pkg::REG_CURVE_B) cb_q <= cfg_wdata_i;
    end
  end

  ecsm_alu #(.W(FW)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .m_i    (m_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res),
    .rem_o  (alu_rem)
  );

  assign fin             = alu_rsp.done;
  assign alu_req.start   = is_op && !issued_q;
  assign alu_req.op      = op;

  // sequencer: next state, operand select and register updates
  always_comb begin
    state_d  = state_q;
    bx_d = bx_q; by_d = by_q; ar_d = ar_q; br_d = br_q;
    ax_d = ax_q; ay_d = ay_q; ox_d = ox_q; av_d = av_q;
    num_d = num_q; den_d = den_q; lam_d = lam_q; e0_d = e0_q; e1_d = e1_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q; qt_d = qt_q; nr_d = nr_q;
    k_d = k_q; i_d = i_q; ph_add_d = ph_add_q;
    ov_d = ov_q; res_d = res_q;
    is_op = 1'b0;
    op    = ecsm_pkg::OP_ADD;
    opa   = '0;
    opb   = '0;

    unique case (state_q)
      ecsm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          bx_d = in_data_i.base_x;
          by_d = in_data_i.base_y;
          k_d  = in_data_i.scalar;
          if (m_q < FW'(2)) begin
            res_d   = '{result_x: '0, result_y: '0, at_infinity: 1'b1, on_curve: 1'b0};
            ov_d    = 1'b1;
            state_d = ecsm_pkg::S_OUT;
          end else begin
            state_d = ecsm_pkg::S_RED_BX;
          end
        end
      end
      // reduce operands modulo p
      ecsm_pkg::S_RED_BX: begin
        is_op = 1'b1; op = ecsm_pkg::OP_DIV; opa = bx_q; opb = m_q;
        if (fin) begin bx_d = alu_rem; state_d = ecsm_pkg::S_RED_BY; end
      end
      ecsm_pkg::S_RED_BY: begin
        is_op = 1'b1; op = ecsm_pkg::OP_DIV; opa = by_q; opb = m_q;
        if (fin) begin by_d = alu_rem; state_d = ecsm_pkg::S_RED_A; end
      end
      ecsm_pkg::S_RED_A: begin
        is_op = 1'b1; op = ecsm_pkg::OP_DIV; opa = ca_q; opb = m_q;
        if (fin) begin ar_d = alu_rem; state_d = ecsm_pkg::S_RED_B; end
      end
      ecsm_pkg::S_RED_B: begin
        is_op = 1'b1; op = ecsm_pkg::OP_DIV; opa = cb_q; opb = m_q;
        if (fin) begin
          br_d     = alu_rem;
          av_d     = 1'b0;
          ax_d     = '0;
          ay_d     = '0;
          i_d      = IW'(SW - 1);
          ph_add_d = 1'b0;
          state_d  = ecsm_pkg::S_DBL_CHK;
        end
      end
      // doubling of the accumulator
      ecsm_pkg::S_DBL_CHK: begin
        state_d = av_q ? ecsm_pkg::S_DBL_NEG : ecsm_pkg::S_ADD_CHK;
      end
      ecsm_pkg::S_DBL_NEG: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = '0; opb = ay_q;
        if (fin) begin
          if (ay_q == alu_res) begin
            av_d = 1'b0; ax_d = '0; ay_d = '0;
            state_d = ecsm_pkg::S_ADD_CHK;
          end else begin
            ox_d = ax_q;
            state_d = ecsm_pkg::S_SQ;
          end
        end
      end
      ecsm_pkg::S_SQ: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = ax_q; opb = ax_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_TRI0; end
      end
      ecsm_pkg::S_TRI0: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = e0_q; opb = e0_q;
        if (fin) begin e1_d = alu_res; state_d = ecsm_pkg::S_TRI1; end
      end
      ecsm_pkg::S_TRI1: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = e1_q; opb = e0_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_ADD_A; end
      end
      ecsm_pkg::S_ADD_A: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = e0_q; opb = ar_q;
        if (fin) begin num_d = alu_res; state_d = ecsm_pkg::S_TWO_Y; end
      end
      ecsm_pkg::S_TWO_Y: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = ay_q; opb = ay_q;
        if (fin) begin den_d = alu_res; state_d = ecsm_pkg::S_INV_INIT; end
      end
      // extended euclid inverse of den
      ecsm_pkg::S_INV_INIT: begin
        r0_d = m_q; r1_d = den_q; t0_d = '0; t1_d = FW'(1);
        state_d = ecsm_pkg::S_INV_TEST;
      end
      ecsm_pkg::S_INV_TEST: begin
        state_d = (r1_q == '0) ? ecsm_pkg::S_INV_END : ecsm_pkg::S_INV_DIV;
      end
      ecsm_pkg::S_INV_DIV: begin
        is_op = 1'b1; op = ecsm_pkg::OP_DIV; opa = r0_q; opb = r1_q;
        if (fin) begin qt_d = alu_res; nr_d = alu_rem; state_d = ecsm_pkg::S_INV_MUL; end
      end
      ecsm_pkg::S_INV_MUL: begin
        // quotient equals p only for r0 = p, r1 = 1, where it reduces to zero
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = (qt_q == m_q) ? '0 : qt_q; opb = t1_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_INV_SUB; end
      end
      ecsm_pkg::S_INV_SUB: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = t0_q; opb = e0_q;
        if (fin) begin
          r0_d = r1_q; r1_d = nr_q; t0_d = t1_q; t1_d = alu_res;
          state_d = ecsm_pkg::S_INV_TEST;
        end
      end
      ecsm_pkg::S_INV_END: begin
        den_d   = (r0_q == FW'(1)) ? t0_q : '0;
        state_d = ecsm_pkg::S_SLOPE;
      end
      // new point from slope
      ecsm_pkg::S_SLOPE: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = num_q; opb = den_q;
        if (fin) begin lam_d = alu_res; state_d = ecsm_pkg::S_LL; end
      end
      ecsm_pkg::S_LL: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = lam_q; opb = lam_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_X1; end
      end
      ecsm_pkg::S_X1: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = e0_q; opb = ax_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_X2; end
      end
      ecsm_pkg::S_X2: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = e0_q; opb = ox_q;
        if (fin) begin e1_d = alu_res; state_d = ecsm_pkg::S_DX; end
      end
      ecsm_pkg::S_DX: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = ax_q; opb = e1_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_LM; end
      end
      ecsm_pkg::S_LM: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = lam_q; opb = e0_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_Y; end
      end
      ecsm_pkg::S_Y: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = e0_q; opb = ay_q;
        if (fin) begin
          ay_d = alu_res; ax_d = e1_q; av_d = 1'b1;
          state_d = ph_add_q ? ecsm_pkg::S_NEXT : ecsm_pkg::S_ADD_CHK;
        end
      end
      // conditional addition of the base point
      ecsm_pkg::S_ADD_CHK: begin
        if (!k_q[i_q]) begin
          state_d = ecsm_pkg::S_NEXT;
        end else if (!av_q) begin
          ax_d = bx_q; ay_d = by_q; av_d = 1'b1;
          state_d = ecsm_pkg::S_NEXT;
        end else begin
          ph_add_d = 1'b1;
          state_d  = ecsm_pkg::S_ADD_NEG;
        end
      end
      ecsm_pkg::S_ADD_NEG: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = '0; opb = by_q;
        if (fin) begin
          if (ax_q == bx_q && ay_q == alu_res) begin
            av_d = 1'b0; ax_d = '0; ay_d = '0;
            state_d = ecsm_pkg::S_NEXT;
          end else if (ax_q == bx_q && ay_q == by_q) begin
            ox_d = ax_q;
            state_d = ecsm_pkg::S_SQ;
          end else begin
            state_d = ecsm_pkg::S_DIFF_Y;
          end
        end
      end
      ecsm_pkg::S_DIFF_Y: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = by_q; opb = ay_q;
        if (fin) begin num_d = alu_res; state_d = ecsm_pkg::S_DIFF_X; end
      end
      ecsm_pkg::S_DIFF_X: begin
        is_op = 1'b1; op = ecsm_pkg::OP_SUB; opa = bx_q; opb = ax_q;
        if (fin) begin
          den_d = alu_res; ox_d = bx_q;
          state_d = ecsm_pkg::S_INV_INIT;
        end
      end
      ecsm_pkg::S_NEXT: begin
        if (i_q == '0) begin
          state_d = ecsm_pkg::S_CHK;
        end else begin
          i_d = i_q - 1'b1; ph_add_d = 1'b0;
          state_d = ecsm_pkg::S_DBL_CHK;
        end
      end
      // curve equation check
      ecsm_pkg::S_CHK: begin
        if (!av_q) begin
          res_d   = '{result_x: '0, result_y: '0, at_infinity: 1'b1, on_curve: 1'b0};
          ov_d    = 1'b1;
          state_d = ecsm_pkg::S_OUT;
        end else begin
          state_d = ecsm_pkg::S_C_LHS;
        end
      end
      ecsm_pkg::S_C_LHS: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = ay_q; opb = ay_q;
        if (fin) begin num_d = alu_res; state_d = ecsm_pkg::S_C_X2; end
      end
      ecsm_pkg::S_C_X2: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = ax_q; opb = ax_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_C_X3; end
      end
      ecsm_pkg::S_C_X3: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = e0_q; opb = ax_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_C_AX; end
      end
      ecsm_pkg::S_C_AX: begin
        is_op = 1'b1; op = ecsm_pkg::OP_MUL; opa = ar_q; opb = ax_q;
        if (fin) begin e1_d = alu_res; state_d = ecsm_pkg::S_C_S1; end
      end
      ecsm_pkg::S_C_S1: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = e0_q; opb = e1_q;
        if (fin) begin e0_d = alu_res; state_d = ecsm_pkg::S_C_S2; end
      end
      ecsm_pkg::S_C_S2: begin
        is_op = 1'b1; op = ecsm_pkg::OP_ADD; opa = e0_q; opb = br_q;
        if (fin) begin
          res_d   = '{result_x: ax_q, result_y: ay_q, at_infinity: 1'b0,
                      on_curve: (num_q == alu_res)};
          ov_d    = 1'b1;
          state_d = ecsm_pkg::S_OUT;
        end
      end
      // result transfer
      ecsm_pkg::S_OUT: begin
        if (!out_stall_i) begin
          ov_d    = 1'b0;
          state_d = ecsm_pkg::S_IDLE;
        end
      end
      default: state_d = ecsm_pkg::S_IDLE;
    endcase

    issued_d = is_op && !fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecsm_pkg::S_IDLE;
      issued_q <= 1'b0;
      ov_q     <= 1'b0;
      av_q     <= 1'b0;
      ph_add_q <= 1'b0;
      i_q      <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ov_q     <= ov_d;
      av_q     <= av_d;
      ph_add_q <= ph_add_d;
      i_q      <= i_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    bx_q <= bx_d; by_q <= by_d; ar_q <= ar_d; br_q <= br_d;
    ax_q <= ax_d; ay_q <= ay_d; ox_q <= ox_d;
    num_q <= num_d; den_q <= den_d; lam_q <= lam_d; e0_q <= e0_d; e1_q <= e1_d;
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d; qt_q <= qt_d; nr_q <= nr_d;
    k_q <= k_d;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != ecsm_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

`ifndef ASSERT_OFF
  // input is taken only when no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> !out_valid_o)
    else $error("input open while result pending");
  // infinity carries zero coordinates and fails the curve test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.at_infinity)
      |-> (out_data_o.result_x == '0 && out_data_o.result_y == '0 && !out_data_o.on_curve))
    else $error("bad infinity result");
  // the shared unit finishes only while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q != ecsm_pkg::S_IDLE && state_q != ecsm_pkg::S_OUT))
    else $error("unit finished outside a computation");
  // a result leaves the output state once transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o && state_q == ecsm_pkg::S_IDLE))
    else $error("result not released after transfer");
`endif

endmodule
